// ----- design/tfr_pkg.sv -----
`timescale 1ns / 1ps
package tfr_pkg;

    // ring geometry
    localparam int SLOT_COUNT      = 16;
    localparam int MAX_FRAME_BYTES = 32;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);          // ring slot index
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);      // 0..SLOT_COUNT
    localparam int PHYS_W    = $clog2(SLOT_COUNT + 1);      // one spare buffer
    localparam int BIDX_W    = $clog2(MAX_FRAME_BYTES);     // byte within buffer
    localparam int PAY_DEPTH = (SLOT_COUNT + 1) * MAX_FRAME_BYTES;
    localparam int PAY_AW    = $clog2(PAY_DEPTH);

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int LEN_W  = 6;
    localparam int TS_W   = 64;
    localparam int IDX_W  = 4;
    localparam int BYTE_W = 8;
    localparam int PCNT_W = 64;

    // configuration port
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 6;
    localparam logic [CFG_IW-1:0] CFG_RING_CAPACITY    = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_SIZE_LIMIT = 1'd1;
    localparam int CAP_RST   = 16;
    localparam int LIMIT_RST = 32;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // opcodes
    localparam logic [OP_W-1:0] OP_PUSH_BYTE  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_EMPTY = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_OLD   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_NEW   = 3'd3;
    localparam logic [OP_W-1:0] OP_POP        = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    typedef enum logic [2:0] {
        K_PUSH_BYTE,
        K_PUSH_EMPTY,
        K_READ_OLD,
        K_READ_NEW,
        K_POP,
        K_CLEAR,
        K_NOP
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LEN,
        BK_STREAM
    } bk_state_t;

    typedef struct packed {
        logic [OP_W-1:0]        opcode;
        logic [BYTE_W-1:0]      in_byte;
        logic                   frame_last;
        logic signed [TS_W-1:0] in_timestamp;
        logic [IDX_W-1:0]       slot_index;
        logic [LEN_W-1:0]       read_limit;
    } in_t;

    typedef struct packed {
        logic                   status;
        logic [LEN_W-1:0]       frame_length;
        logic signed [TS_W-1:0] out_timestamp;
        logic [BYTE_W-1:0]      out_byte;
        logic                   byte_valid;
        logic                   result_last;
        logic [CNT_W-1:0]       frames_held;
        logic [PCNT_W-1:0]      pushes_total;
    } out_t;

    typedef struct packed {
        kind_t                  kind;
        logic [BYTE_W-1:0]      data_byte;
        logic                   last;
        logic signed [TS_W-1:0] stamp;
        logic [IDX_W-1:0]       idx;
        logic [LEN_W-1:0]       rlim;
    } cmd_t;

endpackage

// ----- design/tfr_front.sv -----
`timescale 1ns / 1ps
module tfr_front (
    input  logic          s_valid,
    output logic          s_ready,
    input  tfr_pkg::in_t  s_data,
    input  logic          q_full,
    output logic          q_push,
    output tfr_pkg::cmd_t q_cmd
);
    import tfr_pkg::*;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd.data_byte = s_data.in_byte;
        q_cmd.last      = s_data.frame_last;
        q_cmd.stamp     = s_data.in_timestamp;
        q_cmd.idx       = s_data.slot_index;
        q_cmd.rlim      = s_data.read_limit;
        unique case (s_data.opcode)
            OP_PUSH_BYTE:  q_cmd.kind = K_PUSH_BYTE;
            OP_PUSH_EMPTY: q_cmd.kind = K_PUSH_EMPTY;
            OP_READ_OLD:   q_cmd.kind = K_READ_OLD;
            OP_READ_NEW:   q_cmd.kind = K_READ_NEW;
            OP_POP:        q_cmd.kind = K_POP;
            OP_CLEAR:      q_cmd.kind = K_CLEAR;
            default:       q_cmd.kind = K_NOP;
        endcase
        // pop always addresses the oldest frame
        if (s_data.opcode == OP_POP) begin
            q_cmd.idx = '0;
        end
    end

endmodule

// ----- design/tfr_queue.sv -----
`timescale 1ns / 1ps
module tfr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tfr_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output tfr_pkg::cmd_t cmd_out
);
    import tfr_pkg::*;

    cmd_t            ent_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, wp_next;
    logic [Q_AW-1:0] rp_reg, rp_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == Q_CW'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign cmd_out = ent_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= cmd_in;
        end
    end

endmodule

// ----- design/tfr_back.sv -----
`timescale 1ns / 1ps
module tfr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  tfr_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    input  logic                          cfg_we,
    input  logic [tfr_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [tfr_pkg::CFG_DW-1:0]    cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tfr_pkg::out_t                 m_data
);
    import tfr_pkg::*;

    localparam int BW = CNT_W + 1;   // room for slot + capacity sums

    bk_state_t state_reg, state_next;

    // ring control
    logic [CNT_W-1:0]  cap_reg;
    logic [LEN_W-1:0]  limit_reg;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [PCNT_W-1:0] push_reg, push_next;
    logic [LEN_W-1:0]  brx_reg, brx_next;
    logic              ovs_reg, ovs_next;

    // slot to physical buffer map, one buffer is always free for assembly
    logic [PHYS_W-1:0] map_reg [SLOT_COUNT];
    logic [PHYS_W-1:0] spare_reg;

    // stores
    logic [BYTE_W-1:0] pay_mem   [PAY_DEPTH];
    logic [LEN_W-1:0]  len_mem   [SLOT_COUNT];
    logic [TS_W-1:0]   stamp_mem [SLOT_COUNT];

    // read job
    logic [PHYS_W-1:0] rphys_reg;
    logic [LEN_W-1:0]  rlen_reg;
    logic [TS_W-1:0]   rstamp_reg;
    logic              rpop_reg;
    logic [LEN_W-1:0]  rlim_reg;
    logic [LEN_W-1:0]  slen_reg;
    logic [LEN_W-1:0]  ridx_reg, ridx_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg;
    logic [BYTE_W-1:0] rdata_reg;

    logic              m_valid_reg;
    out_t              m_data_reg;

    // combinational control
    logic              out_free, go, is_read, rd_ok, rd_start;
    logic [CNT_W-1:0]  pos;
    logic [BW-1:0]     base;
    logic [SLOT_W-1:0] rslot, map_addr;
    logic [PHYS_W-1:0] map_out;
    logic              acc, commit;
    logic [LEN_W-1:0]  brx_after, commit_len, eff_len;
    logic              ovs_after;
    logic              mem_we, mem_re, load_out, stream_load;
    logic [PAY_AW-1:0] mem_waddr, mem_raddr;
    out_t              out_data;

    function automatic logic [PAY_AW-1:0] pay_addr(input logic [PHYS_W-1:0] phys,
                                                   input logic [LEN_W-1:0]  ofs);
        logic [BIDX_W-1:0] b;
        b = ofs[BIDX_W-1:0];
        return PAY_AW'(phys) * PAY_AW'(MAX_FRAME_BYTES) + PAY_AW'(b);
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign go       = (state_reg == BK_IDLE) && q_valid && out_free;
    assign q_pop    = go;
    assign is_read  = (q_cmd.kind == K_READ_OLD) || (q_cmd.kind == K_READ_NEW) ||
                      (q_cmd.kind == K_POP);
    assign rd_ok    = CNT_W'(q_cmd.idx) < held_reg;
    assign rd_start = go && is_read && rd_ok;

    // ring position of the addressed frame
    always_comb begin
        pos   = (q_cmd.kind == K_READ_NEW) ? held_reg - 1'b1 - CNT_W'(q_cmd.idx)
                                           : CNT_W'(q_cmd.idx);
        base  = BW'(wslot_reg) + BW'(cap_reg) - BW'(held_reg) + BW'(pos);
        rslot = (base >= BW'(cap_reg)) ? SLOT_W'(base - BW'(cap_reg)) : SLOT_W'(base);
        map_addr = is_read ? rslot : wslot_reg;
        map_out  = map_reg[map_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (rd_start) begin
                    state_next = BK_LEN;
                end
            end
            BK_LEN: begin
                if (eff_len != '0) begin
                    state_next = BK_STREAM;
                end else if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            BK_STREAM: begin
                if (stream_load && pend_last_reg) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        wslot_next  = wslot_reg;
        held_next   = held_reg;
        push_next   = push_reg;
        brx_next    = brx_reg;
        ovs_next    = ovs_reg;
        ridx_next   = ridx_reg;
        pend_next   = pend_reg;
        acc         = brx_reg < limit_reg;
        brx_after   = acc ? brx_reg + 1'b1 : brx_reg;
        ovs_after   = ovs_reg || !acc;
        commit      = 1'b0;
        commit_len  = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = pay_addr(spare_reg, brx_reg);
        mem_raddr   = pay_addr(rphys_reg, ridx_reg);
        load_out    = 1'b0;
        stream_load = 1'b0;
        eff_len     = (rpop_reg && (rlen_reg > rlim_reg)) ? rlim_reg : rlen_reg;
        out_data    = '0;

        unique case (state_reg)
            BK_IDLE: begin
                if (go) begin
                    case (q_cmd.kind)
                        K_PUSH_BYTE: begin
                            mem_we   = acc;
                            brx_next = brx_after;
                            ovs_next = ovs_after;
                            if (q_cmd.last) begin
                                commit     = 1'b1;
                                commit_len = ovs_after ? '0 : brx_after;
                            end
                        end
                        K_PUSH_EMPTY: begin
                            commit = 1'b1;
                        end
                        K_POP: begin
                            if (rd_ok) begin
                                held_next = held_reg - 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            wslot_next = '0;
                            held_next  = '0;
                            push_next  = '0;
                            brx_next   = '0;
                            ovs_next   = 1'b0;
                        end
                        default: ;
                    endcase
                    if (commit) begin
                        wslot_next = (CNT_W'(wslot_reg) + 1'b1 == cap_reg) ? '0
                                                                          : wslot_reg + 1'b1;
                        held_next  = (held_reg < cap_reg) ? held_reg + 1'b1 : held_reg;
                        push_next  = push_reg + 1'b1;
                        brx_next   = '0;
                        ovs_next   = 1'b0;
                    end
                    // a valid read streams from the read states, all else answers now
                    load_out               = !rd_start;
                    out_data.status        = is_read && !rd_ok;
                    out_data.frame_length  = commit_len;
                    out_data.out_timestamp = commit ? q_cmd.stamp : '0;
                    out_data.result_last   = 1'b1;
                    out_data.frames_held   = held_next;
                    out_data.pushes_total  = push_next;
                end
            end
            BK_LEN: begin
                ridx_next = '0;
                pend_next = 1'b0;
                if (eff_len == '0) begin
                    load_out               = out_free;
                    out_data.out_timestamp = rstamp_reg;
                    out_data.result_last   = 1'b1;
                    out_data.frames_held   = held_reg;
                    out_data.pushes_total  = push_reg;
                end
            end
            BK_STREAM: begin
                stream_load = pend_reg && out_free;
                mem_re      = (ridx_reg < slen_reg) && (!pend_reg || stream_load);
                load_out    = stream_load;
                if (mem_re) begin
                    ridx_next = ridx_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (stream_load) begin
                    pend_next = 1'b0;
                end
                out_data.frame_length  = slen_reg;
                out_data.out_timestamp = rstamp_reg;
                out_data.out_byte      = rdata_reg;
                out_data.byte_valid    = 1'b1;
                out_data.result_last   = pend_last_reg;
                out_data.frames_held   = held_reg;
                out_data.pushes_total  = push_reg;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            cap_reg     <= CNT_W'(CAP_RST);
            limit_reg   <= LEN_W'(LIMIT_RST);
            wslot_reg   <= '0;
            held_reg    <= '0;
            push_reg    <= '0;
            brx_reg     <= '0;
            ovs_reg     <= 1'b0;
            ridx_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            spare_reg   <= PHYS_W'(SLOT_COUNT);
            for (int i = 0; i < SLOT_COUNT; i++) begin
                map_reg[i] <= PHYS_W'(i);
            end
        end else begin
            state_reg <= state_next;
            ridx_reg  <= ridx_next;
            pend_reg  <= pend_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_RING_CAPACITY: begin
                        if (cfg_data[CNT_W-1:0] == '0) begin
                            cap_reg <= CNT_W'(1);
                        end else if (cfg_data[CNT_W-1:0] > CNT_W'(SLOT_COUNT)) begin
                            cap_reg <= CNT_W'(SLOT_COUNT);
                        end else begin
                            cap_reg <= cfg_data[CNT_W-1:0];
                        end
                    end
                    CFG_FRAME_SIZE_LIMIT: begin
                        limit_reg <= (cfg_data > LEN_W'(MAX_FRAME_BYTES))
                                     ? LEN_W'(MAX_FRAME_BYTES) : cfg_data;
                    end
                    default: ;
                endcase
                // either write restarts the ring
                wslot_reg <= '0;
                held_reg  <= '0;
                push_reg  <= '0;
                brx_reg   <= '0;
                ovs_reg   <= 1'b0;
            end else begin
                wslot_reg <= wslot_next;
                held_reg  <= held_next;
                push_reg  <= push_next;
                brx_reg   <= brx_next;
                ovs_reg   <= ovs_next;
                // swap the assembled buffer into the ring slot
                if (commit) begin
                    map_reg[wslot_reg] <= spare_reg;
                    spare_reg          <= map_out;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= out_data;
        end
        if (commit) begin
            len_mem[wslot_reg]   <= commit_len;
            stamp_mem[wslot_reg] <= q_cmd.stamp;
        end
        if (rd_start) begin
            rlen_reg   <= len_mem[rslot];
            rstamp_reg <= stamp_mem[rslot];
            rphys_reg  <= map_out;
            rpop_reg   <= (q_cmd.kind == K_POP);
            rlim_reg   <= q_cmd.rlim;
        end
        if (state_reg == BK_LEN) begin
            slen_reg <= eff_len;
        end
        if (mem_re) begin
            pend_last_reg <= (ridx_reg + 1'b1 == slen_reg);
        end
    end

    // payload memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pay_mem[mem_waddr] <= q_cmd.data_byte;
        end
        if (mem_re) begin
            rdata_reg <= pay_mem[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_held_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= cap_reg)
        else $error("held count above capacity");

    a_wslot_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(wslot_reg) < cap_reg)
        else $error("write slot outside capacity");

    a_brx_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        brx_reg <= limit_reg)
        else $error("assembly count above frame limit");

    a_stream_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_STREAM) |-> (ridx_reg <= slen_reg))
        else $error("stream index past frame length");

    a_no_load_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !load_out)
        else $error("result register overwritten while stalled");

endmodule

// ----- design/timestamped_frame_ring_top.sv -----
`timescale 1ns / 1ps
// Ring of timestamped frames with overwrite of the oldest frame.
// s_ channel: one command beat per item (push byte, push empty frame, read by
//   oldest or newest index, pop oldest, clear). valid/ready, taken when both high.
// m_ channel: result beats; a frame read of L bytes (a pop caps L at read_limit) gives
//   L one-byte beats, or one if L is 0; every other item gives one; result_last closes an item.
// cfg_we/cfg_index/cfg_data: single cycle register write (capacity, frame limit),
//   only while the block is idle; either write empties the ring.
// Throughput: single-beat items run at one per cycle while the receiver takes each
//   beat; a read first does slot lookup, length select and a first memory read,
//   then streams one byte per cycle out of the payload memory's registered read
//   port while the receiver keeps up, and no new item starts until the read ends.
// Reset: ring empty, counts zero, capacity 16 slots, frame limit 32 bytes.
// When the receiver stalls, the result register holds its beat, the back end
//   stops, the two-entry command queue fills and s_ready drops.
module timestamped_frame_ring_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tfr_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tfr_pkg::out_t                 m_data,
    input  logic                          cfg_we,
    input  logic [tfr_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [tfr_pkg::CFG_DW-1:0]    cfg_data
);
    import tfr_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t cmd_in, cmd_out;

    // front: decode the command beat into a queue entry
    tfr_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (cmd_in)
    );

    // short queue so input and result sides stall independently
    tfr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (cmd_in),
        .full    (q_full),
        .pop     (q_pop),
        .q_valid (q_valid),
        .cmd_out (cmd_out)
    );

    // back: ring state, stores and result streaming
    tfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (cmd_out),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import tfr_pkg::*;

    // opcodes the block leaves unused, they must still give one plain beat
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic [TS_W-1:0] TS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [TS_W-1:0] TS_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [TS_W-1:0] TS_ONES = '1;

    localparam int DRAIN_PAD   = 8;
    localparam int HOLD_CYCLES = 120;        // long receiver stall, fills the command queue
    localparam int TIMEOUT_NS  = 6_000_000;

    // one row of the directed script: a register write or a command beat,
    // optionally with the single result beat typed in by hand
    typedef struct packed {
        bit                 is_cfg;
        logic [CFG_IW-1:0]  cfg_idx;
        logic [CFG_DW-1:0]  cfg_val;
        in_t                item;
        bit                 typed;
        out_t               want;
    } script_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    timestamped_frame_ring_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // frame ring predictor: own copy of the stores, indices and counts
    // ---------------------------------------------------------------
    logic [BYTE_W-1:0] frame_bytes [SLOT_COUNT][MAX_FRAME_BYTES];
    int unsigned       frame_len   [SLOT_COUNT];
    logic [TS_W-1:0]   frame_stamp [SLOT_COUNT];
    logic [BYTE_W-1:0] rx_buf      [MAX_FRAME_BYTES];   // frame being streamed in
    int unsigned       wr_slot;
    int unsigned       n_held;
    logic [PCNT_W-1:0] n_pushes;
    int unsigned       rx_count;
    bit                rx_oversize;
    logic [4:0]        cap_reg;
    logic [5:0]        limit_reg;

    out_t        step_beats [$];   // beats caused by the command just taken
    out_t        owed_beats [$];   // beats the block still has to deliver
    script_row_t script [$];
    int unsigned items_sent = 0;
    int unsigned bad_beats  = 0;

    // traffic shaping, shared with the receiver process
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit hold_req   = 1'b0;

    function automatic int unsigned cap_in_use();
        if (cap_reg == 0) return 1;
        if (cap_reg > SLOT_COUNT) return SLOT_COUNT;
        return cap_reg;
    endfunction

    function automatic int unsigned limit_in_use();
        return (limit_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : limit_reg;
    endfunction

    function automatic void ring_reinit();
        wr_slot     = 0;
        n_held      = 0;
        n_pushes    = '0;
        rx_count    = 0;
        rx_oversize = 1'b0;
    endfunction

    function automatic out_t beat(logic st, int unsigned len, logic [TS_W-1:0] ts,
                                  logic [BYTE_W-1:0] b, logic bv, logic last,
                                  int unsigned held, logic [PCNT_W-1:0] pushes);
        out_t r;
        r.status        = st;
        r.frame_length  = len[LEN_W-1:0];
        r.out_timestamp = ts;
        r.out_byte      = b;
        r.byte_valid    = bv;
        r.result_last   = last;
        r.frames_held   = held[CNT_W-1:0];
        r.pushes_total  = pushes;
        return r;
    endfunction

    // closing beat with no payload byte
    function automatic out_t done_beat(logic st, int unsigned len, logic [TS_W-1:0] ts,
                                       int unsigned held, logic [PCNT_W-1:0] pushes);
        return beat(st, len, ts, '0, 1'b0, 1'b1, held, pushes);
    endfunction

    // store the assembled frame at the write slot, overwriting the oldest when full
    function automatic void ring_commit(int unsigned len, logic [TS_W-1:0] ts);
        int unsigned cap;
        int unsigned s;
        cap = cap_in_use();
        s   = wr_slot % cap;
        for (int k = 0; k < len; k++) frame_bytes[s][k] = rx_buf[k];
        frame_len[s]   = len;
        frame_stamp[s] = ts;
        wr_slot = (s + 1) % cap;
        if (n_held < cap) n_held++;
        n_pushes++;
        rx_count    = 0;
        rx_oversize = 1'b0;
    endfunction

    function automatic void frame_ring_step(in_t it);
        int unsigned cap;
        int unsigned idx;
        int unsigned pos;
        int unsigned s;
        int unsigned len;
        logic [TS_W-1:0] stamp;
        step_beats.delete();
        case (it.opcode)
            OP_PUSH_BYTE: begin
                if (rx_count < limit_in_use()) begin
                    rx_buf[rx_count % MAX_FRAME_BYTES] = it.in_byte;
                    rx_count++;
                end else begin
                    rx_oversize = 1'b1;
                end
                if (it.frame_last) begin
                    // oversize frames are kept, but with no payload
                    len = rx_oversize ? 0 : rx_count;
                    ring_commit(len, it.in_timestamp);
                    step_beats.push_back(done_beat(1'b0, len, it.in_timestamp,
                                                   n_held, n_pushes));
                end else begin
                    step_beats.push_back(done_beat(1'b0, 0, '0, n_held, n_pushes));
                end
            end
            OP_PUSH_EMPTY: begin
                // a partly streamed frame is thrown away
                rx_count    = 0;
                rx_oversize = 1'b0;
                ring_commit(0, it.in_timestamp);
                step_beats.push_back(done_beat(1'b0, 0, it.in_timestamp, n_held, n_pushes));
            end
            OP_READ_OLD, OP_READ_NEW, OP_POP: begin
                cap = cap_in_use();
                idx = (it.opcode == OP_POP) ? 0 : it.slot_index;
                if (idx >= n_held) begin
                    step_beats.push_back(done_beat(1'b1, 0, '0, n_held, n_pushes));
                end else begin
                    pos   = (it.opcode == OP_READ_NEW) ? n_held - 1 - idx : idx;
                    s     = ((wr_slot % cap) + cap - n_held + pos) % cap;
                    len   = frame_len[s];
                    stamp = frame_stamp[s];
                    if (it.opcode == OP_POP) begin
                        if (len > it.read_limit) len = it.read_limit;
                        n_held--;
                    end
                    if (len == 0) begin
                        step_beats.push_back(done_beat(1'b0, 0, stamp, n_held, n_pushes));
                    end else begin
                        for (int k = 0; k < len; k++)
                            step_beats.push_back(beat(1'b0, len, stamp, frame_bytes[s][k],
                                                      1'b1, k == len - 1, n_held, n_pushes));
                    end
                end
            end
            OP_CLEAR: begin
                ring_reinit();
                step_beats.push_back(done_beat(1'b0, 0, '0, n_held, n_pushes));
            end
            default: begin
                step_beats.push_back(done_beat(1'b0, 0, '0, n_held, n_pushes));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic in_t random_item();
        in_t it;
        it.opcode       = 3'($urandom_range(0, 7));
        it.in_byte      = 8'($urandom);
        it.frame_last   = 1'($urandom);
        it.in_timestamp = {$urandom, $urandom};
        it.slot_index   = 4'($urandom);
        it.read_limit   = 6'($urandom);
        return it;
    endfunction

    function automatic script_row_t row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                                        logic last, logic [TS_W-1:0] ts,
                                        logic [IDX_W-1:0] idx, logic [LEN_W-1:0] rlim);
        script_row_t r;
        r = '0;
        r.item.opcode       = op;
        r.item.in_byte      = b;
        r.item.frame_last   = last;
        r.item.in_timestamp = ts;
        r.item.slot_index   = idx;
        r.item.read_limit   = rlim;
        return r;
    endfunction

    function automatic script_row_t checked(script_row_t r, out_t want);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic script_row_t cfg_row(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        script_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // offer one command beat, hold it until taken, then predict its results;
    // called and returning at a falling edge
    task automatic send_item(in_t it, bit typed, out_t want);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_ring_step(it);
        if (typed) begin
            owed_beats.push_back(want);
        end else begin
            foreach (step_beats[k]) owed_beats.push_back(step_beats[k]);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // stream n payload bytes; an open frame is left without its last mark
    task automatic send_frame(int unsigned n, bit closed);
        in_t it;
        for (int k = 0; k < n; k++) begin
            it = random_item();
            it.opcode     = OP_PUSH_BYTE;
            it.frame_last = closed && (k == n - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    // block idle: nothing offered, nothing owed, pipeline flushed
    task automatic ring_drain();
        s_valid <= 1'b0;
        while (owed_beats.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        // either register write empties the ring
        if (idx == CFG_RING_CAPACITY) cap_reg = val[4:0];
        else limit_reg = val;
        ring_reinit();
    endtask

    // one random phase under a given setting, mostly whole frames and reads
    task automatic run_phase(logic [CFG_DW-1:0] cap, logic [CFG_DW-1:0] lim, int unsigned n,
                             bit tx_idle, bit rx_idle, bit pressure);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        int unsigned fl;
        in_t it;
        ring_drain();
        write_reg(CFG_RING_CAPACITY, cap);
        write_reg(CFG_FRAME_SIZE_LIMIT, lim);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        if (pressure) hold_req = 1'b1;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            fl   = limit_in_use();
            it   = random_item();
            if (pick < 40) begin
                // whole frame, now and then longer than the limit
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, fl + 2);
                else len = $urandom_range(1, (fl < 5) ? fl + 1 : 5);
                send_frame(len, 1'b1);
            end else if (pick < 50) begin
                it.opcode = OP_PUSH_EMPTY;
                send_item(it, 1'b0, '0);
            end else if (pick < 55) begin
                // broken frame, cut off by an empty push
                send_frame($urandom_range(1, 3), 1'b0);
                it.opcode = OP_PUSH_EMPTY;
                send_item(it, 1'b0, '0);
            end else if (pick < 80) begin
                it.opcode = $urandom_range(0, 1) ? OP_READ_NEW : OP_READ_OLD;
                if (n_held != 0 && $urandom_range(0, 9) < 8)
                    it.slot_index = 4'($urandom_range(0, n_held - 1));
                send_item(it, 1'b0, '0);
            end else if (pick < 92) begin
                it.opcode = OP_POP;
                if ($urandom_range(0, 3) == 0) it.read_limit = 6'($urandom_range(0, 3));
                send_item(it, 1'b0, '0);
            end else if (pick < 96) begin
                it.opcode = OP_CLEAR;
                send_item(it, 1'b0, '0);
            end else begin
                it.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    task automatic report_beat(string what, out_t want, out_t got);
        if (bad_beats < 10) begin
            $display("%s want: st=%0d len=%0d ts=%h byte=%h bv=%0d last=%0d held=%0d n=%0d",
                     what, want.status, want.frame_length, want.out_timestamp, want.out_byte,
                     want.byte_valid, want.result_last, want.frames_held, want.pushes_total);
            $display("%s got:  st=%0d len=%0d ts=%h byte=%h bv=%0d last=%0d held=%0d n=%0d",
                     what, got.status, got.frame_length, got.out_timestamp, got.out_byte,
                     got.byte_valid, got.result_last, got.frames_held, got.pushes_total);
        end
        bad_beats++;
    endtask

    // ---------------------------------------------------------------
    // result monitor: every taken beat against the oldest owed beat
    // ---------------------------------------------------------------
    out_t oldest_beat;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_beats.size() == 0) begin
                report_beat("unexpected beat", '0, m_data);
            end else begin
                oldest_beat = owed_beats.pop_front();
                if (m_data.status !== oldest_beat.status ||
                    m_data.frame_length !== oldest_beat.frame_length ||
                    m_data.out_timestamp !== oldest_beat.out_timestamp ||
                    m_data.out_byte !== oldest_beat.out_byte ||
                    m_data.byte_valid !== oldest_beat.byte_valid ||
                    m_data.result_last !== oldest_beat.result_last ||
                    m_data.frames_held !== oldest_beat.frames_held ||
                    m_data.pushes_total !== oldest_beat.pushes_total)
                    report_beat("mismatch", oldest_beat, m_data);
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: short random stalls, or one long hold on request
    // ---------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long hold, counted here while the sender keeps offering
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cap_reg   = 5'(CAP_RST);
        limit_reg = 6'(LIMIT_RST);
        ring_reinit();

        // reads and pops of the empty ring after reset
        script.push_back(checked(row(OP_READ_OLD, 8'h00, 1'b0, '0, 4'd0, 6'd0),
                                 done_beat(1'b1, 0, '0, 0, 0)));
        script.push_back(checked(row(OP_READ_NEW, 8'h00, 1'b0, '0, 4'd15, 6'd63),
                                 done_beat(1'b1, 0, '0, 0, 0)));
        script.push_back(checked(row(OP_POP, 8'h00, 1'b0, '0, 4'd0, 6'd32),
                                 done_beat(1'b1, 0, '0, 0, 0)));
        // two byte frame with extreme bytes and the largest timestamp
        script.push_back(checked(row(OP_PUSH_BYTE, 8'h00, 1'b0, TS_MIN, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, '0, 0, 0)));
        script.push_back(checked(row(OP_PUSH_BYTE, 8'hFF, 1'b1, TS_MAX, 4'd15, 6'd63),
                                 done_beat(1'b0, 2, TS_MAX, 1, 1)));
        script.push_back(checked(row(OP_PUSH_EMPTY, 8'hFF, 1'b1, TS_MIN, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, TS_MIN, 2, 2)));
        script.push_back(row(OP_READ_OLD, 8'h00, 1'b0, '0, 4'd0, 6'd0));
        script.push_back(row(OP_READ_NEW, 8'h00, 1'b0, '0, 4'd0, 6'd0));
        // index past the held frames
        script.push_back(checked(row(OP_READ_OLD, 8'h00, 1'b0, '0, 4'd2, 6'd0),
                                 done_beat(1'b1, 0, '0, 2, 2)));
        // empty push cuts off a partly streamed frame
        script.push_back(checked(row(OP_PUSH_BYTE, 8'hA5, 1'b0, TS_ONES, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, '0, 2, 2)));
        script.push_back(checked(row(OP_PUSH_EMPTY, 8'h00, 1'b0, 64'd1, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, 64'd1, 3, 3)));
        script.push_back(checked(row(OP_SPARE_A, 8'hFF, 1'b1, TS_ONES, 4'd15, 6'd63),
                                 done_beat(1'b0, 0, '0, 3, 3)));
        script.push_back(checked(row(OP_SPARE_B, 8'hFF, 1'b1, TS_ONES, 4'd15, 6'd63),
                                 done_beat(1'b0, 0, '0, 3, 3)));
        // pop with a zero limit still removes the frame
        script.push_back(checked(row(OP_POP, 8'h00, 1'b0, '0, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, TS_MAX, 2, 3)));
        script.push_back(row(OP_READ_NEW, 8'h00, 1'b0, '0, 4'd1, 6'd0));
        script.push_back(checked(row(OP_CLEAR, 8'h00, 1'b0, TS_ONES, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, '0, 0, 0)));
        // single slot ring: the second frame overwrites the first
        script.push_back(cfg_row(CFG_RING_CAPACITY, 6'd1));
        script.push_back(checked(row(OP_PUSH_BYTE, 8'h11, 1'b1, 64'd5, 4'd0, 6'd0),
                                 done_beat(1'b0, 1, 64'd5, 1, 1)));
        script.push_back(checked(row(OP_PUSH_BYTE, 8'h22, 1'b1, 64'd6, 4'd0, 6'd0),
                                 done_beat(1'b0, 1, 64'd6, 1, 2)));
        script.push_back(row(OP_POP, 8'h00, 1'b0, '0, 4'd0, 6'd63));
        // one byte limit: a second byte makes the frame oversize
        script.push_back(cfg_row(CFG_FRAME_SIZE_LIMIT, 6'd1));
        script.push_back(checked(row(OP_PUSH_BYTE, 8'h33, 1'b0, '0, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, '0, 0, 0)));
        script.push_back(checked(row(OP_PUSH_BYTE, 8'h44, 1'b1, TS_ONES, 4'd0, 6'd0),
                                 done_beat(1'b0, 0, TS_ONES, 1, 1)));
        script.push_back(row(OP_READ_OLD, 8'h00, 1'b0, '0, 4'd0, 6'd0));
        script.push_back(checked(row(OP_PUSH_BYTE, 8'h55, 1'b1, '0, 4'd0, 6'd0),
                                 done_beat(1'b0, 1, '0, 1, 2)));
        script.push_back(row(OP_READ_NEW, 8'h00, 1'b0, '0, 4'd0, 6'd0));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed script
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                ring_drain();
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            end else begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        // random phases: capacity, frame limit, beats, sender idle, receiver idle, hold
        run_phase(6'd0,  6'd0,  20, 1'b1, 1'b1, 1'b0);
        run_phase(6'd31, 6'd63, 30, 1'b0, 1'b0, 1'b1);
        run_phase(6'd4,  6'd8,  30, 1'b1, 1'b0, 1'b0);
        run_phase(6'd16, 6'd32, 30, 1'b1, 1'b1, 1'b0);
        run_phase(6'd3,  6'd1,  20, 1'b0, 1'b1, 1'b0);
        run_phase(6'd2,  6'd5,  20, 1'b1, 1'b1, 1'b0);
        // closing stretch at full rate on both sides
        run_phase(6'd9,  6'd12, 22, 1'b0, 1'b0, 1'b0);
        ring_drain();

        if (bad_beats == 0 && owed_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
